// File: hdl/dmn_pkg.sv
// Shared types and constants for the division magic number core.
package dmn_pkg;

   // Sequencer states, one-hot coded.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_STRIP  = 5'b00010,
      ST_SCALE  = 5'b00100,
      ST_SEARCH = 5'b01000,
      ST_DONE   = 5'b10000
   } dmn_state_type;

   localparam int unsigned DIV_W   = 32;  // divisor width
   localparam int unsigned ODD_W   = 31;  // odd part width (sign bit is zero when usable)
   localparam int unsigned CNT_W   = 5;   // step counter width
   localparam int unsigned SHIFT_W = 6;   // shift amount width

   // Base exponent is 2^32: 32 doublings of the initial 2^0 / A state.
   localparam logic [CNT_W-1:0] SCALE_LAST = 5'd31;
   // Exponent search stops at 2^62, i.e. 30 steps past 2^32.
   localparam logic [CNT_W-1:0] SEARCH_LAST = 5'd30;
   // 2^(k-31) for k = 32.
   localparam logic [DIV_W-1:0] POW_INIT = 32'd2;

endpackage

// File: hdl/division_magic_number_core.sv
// Signed division by constant: magic multiplier and shift generator.
// An unusable divisor gives the result strobe in the cycle after the start transfer;
// otherwise the sequencer strips trailing zeros, scales to 2^32, searches the exponent
// and then strobes. Scale and search run on one shared doubling/compare/subtract unit.
// busy stays high through the result strobe; the next transfer can start the cycle
// after it, so a new divisor is taken only once the last is done. The receiver cannot stall.
// Reset (synchronous, active high) returns the sequencer to idle, no strobe.
module division_magic_number_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_divisor,
   output logic               rsp_valid,
   output logic [31:0]        rsp_multiplier,
   output logic [5:0]         rsp_shift_amount,
   output logic               rsp_invalid
);
   import dmn_pkg::*;

   dmn_state_type state_ff, state_in;

   logic [ODD_W-1:0]   odd_ff,  odd_in;   // divisor, shifted down to its odd part
   logic [CNT_W-1:0]   tz_ff,   tz_in;    // trailing zeros stripped
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;   // step count (scale, then k - 32)
   logic [ODD_W-1:0]   rem_ff,  rem_in;   // 2^k mod A
   logic [DIV_W-1:0]   quo_ff,  quo_in;   // floor(2^k / A), low 32 bits
   logic [DIV_W-1:0]   pow_ff,  pow_in;   // 2^(k-31), one-hot

   logic [DIV_W-1:0]   mult_ff, mult_in;
   logic [SHIFT_W-1:0] shamt_ff, shamt_in;
   logic               inv_ff,  inv_in;

   // Input screening: negative, 0, 1 and powers of two are rejected.
   logic [DIV_W-1:0] div_raw;
   logic [DIV_W-1:0] div_m1;
   logic             div_bad;

   assign div_raw = unsigned'(req_divisor);
   assign div_m1  = div_raw - 32'd1;
   assign div_bad = div_raw[DIV_W-1] | (div_raw <= 32'd1) | ((div_raw & div_m1) == '0);

   // Shared doubling unit: (q, r) for 2^k  ->  (q, r) for 2^(k+1).
   logic [DIV_W-1:0] dbl_rem;
   logic             dbl_ge;
   logic [DIV_W-1:0] dbl_sub;
   logic [ODD_W-1:0] dbl_rem_next;
   logic [DIV_W-1:0] dbl_quo_next;

   assign dbl_rem      = {rem_ff, 1'b0};
   assign dbl_ge       = dbl_rem >= {1'b0, odd_ff};
   assign dbl_sub      = dbl_rem - {1'b0, odd_ff};
   assign dbl_rem_next = dbl_ge ? dbl_sub[ODD_W-1:0] : dbl_rem[ODD_W-1:0];
   assign dbl_quo_next = {quo_ff[DIV_W-2:0], dbl_ge};

   // Stop test: floor(2^k / gap) >= 2^31  <=>  gap <= 2^(k-31), or the last search step.
   logic [ODD_W-1:0] gap;
   logic             found;

   assign gap   = odd_ff - rem_ff;
   assign found = ({1'b0, gap} <= pow_ff) || (cnt_ff == SEARCH_LAST);

   always_comb begin
      state_in = state_ff;
      odd_in   = odd_ff;
      tz_in    = tz_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      pow_in   = pow_ff;
      mult_in  = mult_ff;
      shamt_in = shamt_ff;
      inv_in   = inv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               odd_in = div_raw[ODD_W-1:0];
               tz_in  = '0;
               if (div_bad) begin
                  mult_in  = '0;
                  shamt_in = '0;
                  inv_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  inv_in   = 1'b0;
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            // one trailing zero per cycle
            if (odd_ff[0]) begin
               cnt_in   = '0;
               rem_in   = {{(ODD_W-1){1'b0}}, 1'b1};  // 2^0 mod A, A >= 3
               quo_in   = '0;
               state_in = ST_SCALE;
            end else begin
               odd_in = odd_ff >> 1;
               tz_in  = tz_ff + 5'd1;
            end
         end
         ST_SCALE: begin
            // bit-serial long division of 2^32 by A
            rem_in = dbl_rem_next;
            quo_in = dbl_quo_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SCALE_LAST) begin
               cnt_in   = '0;
               pow_in   = POW_INIT;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (found) begin
               mult_in  = quo_ff + 32'd1;
               shamt_in = {1'b0, tz_ff} + {1'b0, cnt_ff};
               state_in = ST_DONE;
            end else begin
               rem_in = dbl_rem_next;
               quo_in = dbl_quo_next;
               cnt_in = cnt_ff + 5'd1;
               pow_in = pow_ff << 1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      odd_ff   <= odd_in;
      tz_ff    <= tz_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      pow_ff   <= pow_in;
      mult_ff  <= mult_in;
      shamt_ff <= shamt_in;
      inv_ff   <= inv_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_multiplier   = mult_ff;
   assign rsp_shift_amount = shamt_ff;
   assign rsp_invalid      = inv_ff;

`ifndef SYNTH
   // Accepted transfer always makes the core busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start transfer did not raise busy");

   // Result strobe lasts one cycle and the core then goes idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("result strobe not followed by idle");

   // Rejected divisor gives zero fields.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_multiplier == '0 && rsp_shift_amount == '0))
      else $error("invalid result with nonzero fields");

   // Remainder stays below the odd divisor while dividing.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE || state_ff == ST_SEARCH) |-> (odd_ff[0] && rem_ff < odd_ff))
      else $error("remainder out of range or divisor not odd");

   // Search step tracks a single power of two.
   a_pow_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> $onehot(pow_ff))
      else $error("search bound not a power of two");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for division_magic_number_core: directed and random divisors.
`timescale 1ns / 100ps

module tb_top;
   import dmn_pkg::*;

   // Run limit. It leaves ample headroom for the slowest item plus the largest sender
   // gap over the run's about 650 items.
   localparam int unsigned CYCLE_LIMIT   = 400000;
   // Extra cycles after the last result, beyond the core's worst latency.
   localparam int unsigned SETTLE_CYCLES = 120;

   // Exponent search bounds and the quotient floor it must reach.
   localparam int unsigned     LOG2_BASE  = 32;
   localparam int unsigned     LOG2_CAP   = 62;
   localparam longint unsigned QUOT_FLOOR = 64'd1 << 31;

   // Sender gap draws: full random idling, or a back-to-back stream.
   localparam int unsigned GAP_MAX  = 4;
   localparam int unsigned GAP_NONE = 0;

   typedef struct packed {
      logic [DIV_W-1:0]   multiplier;
      logic [SHIFT_W-1:0] shift_amount;
      logic               invalid;
   } magic_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [DIV_W-1:0] req_divisor;
   logic                    rsp_valid;
   logic [DIV_W-1:0]        rsp_multiplier;
   logic [SHIFT_W-1:0]      rsp_shift_amount;
   logic                    rsp_invalid;

   // Expected results, oldest first.
   magic_type   pending_magic[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   division_magic_number_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_divisor      (req_divisor),
      .rsp_valid        (rsp_valid),
      .rsp_multiplier   (rsp_multiplier),
      .rsp_shift_amount (rsp_shift_amount),
      .rsp_invalid      (rsp_invalid)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Magic number for one divisor: strip trailing zeros, then double
   // L = 2^k from 2^32 until L / (A - L mod A) reaches 2^31, or up to 2^62.
   function automatic magic_type compute_magic(logic signed [DIV_W-1:0] divisor);
      logic [DIV_W-1:0] raw;
      longint unsigned  odd_part;
      longint unsigned  pow_l;
      longint unsigned  gap;
      int unsigned      tz;
      int unsigned      log2l;
      bit               found;
      magic_type        res;
      raw   = divisor;
      res   = '0;
      tz    = 0;
      log2l = LOG2_BASE;
      found = 1'b0;
      // Negative, zero, one and powers of two are rejected.
      if (raw[DIV_W-1] || raw <= 1 || (raw & (raw - 1)) == 0) begin
         res.invalid = 1'b1;
         return res;
      end
      odd_part = raw;
      while (odd_part[0] == 1'b0) begin
         odd_part = odd_part >> 1;
         tz++;
      end
      pow_l = 64'd1 << LOG2_BASE;
      while (log2l < LOG2_CAP && !found) begin
         gap = odd_part - (pow_l % odd_part);
         if (pow_l / gap >= QUOT_FLOOR) begin
            found = 1'b1;
         end else begin
            pow_l = pow_l << 1;
            log2l++;
         end
      end
      res.multiplier   = DIV_W'(pow_l / odd_part + 1);
      res.shift_amount = SHIFT_W'(tz + log2l - LOG2_BASE);
      return res;
   endfunction

   // Usable divisor: random odd part above one, shifted by a random count of
   // trailing zeros, kept below 2^31. Often a small one, as real code uses.
   function automatic logic signed [DIV_W-1:0] pick_usable_divisor();
      logic [DIV_W-1:0] odd_part;
      int unsigned      tz;
      if ($urandom_range(0, 3) == 0) begin
         odd_part = $urandom_range(1, 127) * 2 + 1;
         tz       = $urandom_range(0, 6);
      end else begin
         tz       = $urandom_range(0, 29);
         odd_part = ($urandom & ((32'd1 << (31 - tz)) - 1)) | 32'd1;
         if (odd_part == 32'd1)
            odd_part = 32'd3;
      end
      return odd_part << tz;
   endfunction

   // Any divisor, weighted toward the rejected classes.
   function automatic logic signed [DIV_W-1:0] pick_any_divisor();
      case ($urandom_range(0, 7))
         0:       return 32'd1 << $urandom_range(0, 31);  // powers of two, 2^31 too
         1:       return $signed($urandom_range(0, 8)) - 4; // small, around zero
         2:       return pick_usable_divisor();
         default: return $urandom;
      endcase
   endfunction

   // One transfer on the command port. start stays high afterwards so a
   // back-to-back follow-up never lowers and raises it in one time step.
   task automatic send_divisor(input logic signed [DIV_W-1:0] divisor,
                               input int unsigned max_gap);
      int unsigned gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_divisor <= divisor;
      // Transfer happens at the first edge that sees busy low.
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_magic.push_back(compute_magic(divisor));
   endtask

   // Sender holds off until every expected result is back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_magic.size() != 0) @(posedge clock);
   endtask

   // Edges of the field and every special case of the search.
   task automatic test_corner_divisors();
      send_divisor(32'sd0, GAP_MAX);
      send_divisor(32'sd1, GAP_MAX);
      send_divisor(-32'sd1, GAP_MAX);
      send_divisor(-32'sd3, GAP_MAX);
      send_divisor(32'sh8000_0000, GAP_MAX);      // most negative, also a power of two
      send_divisor(32'sh8000_0003, GAP_MAX);
      send_divisor(32'sd2, GAP_MAX);
      send_divisor(32'sd4, GAP_MAX);
      send_divisor(32'sh4000_0000, GAP_MAX);      // largest positive power of two
      send_divisor(32'sd3, GAP_MAX);              // smallest usable
      send_divisor(32'sd5, GAP_MAX);
      send_divisor(32'sd6, GAP_MAX);
      send_divisor(32'sd7, GAP_MAX);
      send_divisor(32'sd10, GAP_MAX);
      send_divisor(32'sd12, GAP_MAX);
      send_divisor(32'sd25, GAP_MAX);
      send_divisor(32'sd641, GAP_MAX);
      send_divisor(32'sd1000000007, GAP_MAX);
      send_divisor(32'sh7FFF_FFFF, GAP_MAX);      // largest positive
      send_divisor(32'sh7FFF_FFFE, GAP_MAX);
      send_divisor(32'sh6000_0000, GAP_MAX);      // most trailing zeros for a usable one
      send_divisor(32'sh4000_0001, GAP_MAX);
      send_divisor(32'sh5555_5555, GAP_MAX);
      send_divisor(32'sh2AAA_AAAA, GAP_MAX);
   endtask

   // Bulk of the run: usable divisors, so every item runs the exponent search.
   task automatic test_usable_divisors(input int unsigned count);
      repeat (count) send_divisor(pick_usable_divisor(), GAP_MAX);
   endtask

   // Whole 32-bit range, rejected classes included.
   task automatic test_any_divisors(input int unsigned count);
      repeat (count) send_divisor(pick_any_divisor(), GAP_MAX);
   endtask

   // Back-to-back commands: a new transfer the first cycle busy drops.
   task automatic test_back_to_back(input int unsigned count);
      repeat (count) send_divisor(pick_any_divisor(), GAP_NONE);
   endtask

   // Result checker: one strobe, one transfer, compared to the oldest expectation.
   always @(posedge clock) begin
      magic_type want;
      if (!reset && rsp_valid) begin
         if (pending_magic.size() == 0) begin
            $error("unexpected result: multiplier %h shift_amount %0d invalid %b",
                   rsp_multiplier, rsp_shift_amount, rsp_invalid);
            error_count++;
         end else begin
            want = pending_magic.pop_front();
            if (rsp_multiplier !== want.multiplier) begin
               $error("multiplier: expected %h, actual %h", want.multiplier, rsp_multiplier);
               error_count++;
            end
            if (rsp_shift_amount !== want.shift_amount) begin
               $error("shift_amount: expected %0d, actual %0d",
                      want.shift_amount, rsp_shift_amount);
               error_count++;
            end
            if (rsp_invalid !== want.invalid) begin
               $error("invalid: expected %b, actual %b", want.invalid, rsp_invalid);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_divisor <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_corner_divisors();
      drain_results();
      test_usable_divisors(380);
      drain_results();
      test_any_divisors(200);
      test_back_to_back(50);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_magic.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
